/* src/cbg_pkg.sv */
// Shared constants, types and the scale reciprocal table of the calibration box generator.
`default_nettype none

package cbg_pkg;

	// Coordinate and field width of positions, sizes and image dimensions.
	localparam int COORD_W = 12;
	// Default side of the detection window in pixels.
	localparam int WINDOW_SIZE_DEF = 12;

	// Fixed point format of reciprocals and the shift fraction.
	localparam int Q_BITS = 14;
	localparam int RECIP_W = 15;
	localparam int SHIFT_MUL_W = 12;
	localparam logic [SHIFT_MUL_W-1:0] SHIFT_Q14 = 12'd2785;

	// Pattern grid: scales outer, horizontal shift, vertical shift inner.
	localparam int NUM_SCALES = 5;
	localparam int NUM_SHIFTS = 3;
	localparam int SCALE_W = 3;
	localparam int SHIFT_IDX_W = 2;
	localparam int PATTERN_W = 6;

	// Shift codes: the negative shift moves the edge forward by the offset.
	localparam logic [SHIFT_IDX_W-1:0] SHIFT_NEG = 2'd0;
	localparam logic [SHIFT_IDX_W-1:0] SHIFT_ZERO = 2'd1;
	localparam logic [SHIFT_IDX_W-1:0] SHIFT_POS = 2'd2;

	// Register file.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_SEL_BIT = 2;
	localparam logic [COORD_W-1:0] IMG_W_RESET = 12'd640;
	localparam logic [COORD_W-1:0] IMG_H_RESET = 12'd480;

	typedef enum logic {
		REG_IMAGE_WIDTH = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	// Reciprocal of each scale in Q1.14, truncated.
	function automatic logic [RECIP_W-1:0] recip_q14(input logic [SCALE_W-1:0] sn);
		logic [RECIP_W-1:0] r;
		case (sn)
			3'd0: r = 15'd19739;
			3'd1: r = 15'd18004;
			3'd2: r = 15'd16384;
			3'd3: r = 15'd14894;
			3'd4: r = 15'd13540;
			default: r = 15'd16384;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/cbg_if.sv */
// Request and box channel interfaces of the calibration box generator.
`default_nettype none

interface cbg_req_if;
	logic valid;
	logic ready;
	logic [cbg_pkg::COORD_W-1:0] level_width;
	logic [cbg_pkg::COORD_W-1:0] win_row;
	logic [cbg_pkg::COORD_W-1:0] win_col;

	modport source (
		output valid, level_width, win_row, win_col,
		input ready
	);
	modport sink (
		input valid, level_width, win_row, win_col,
		output ready
	);
endinterface

interface cbg_box_if;
	logic valid;
	logic ready;
	logic [cbg_pkg::COORD_W-1:0] box_x;
	logic [cbg_pkg::COORD_W-1:0] box_y;
	logic [cbg_pkg::COORD_W-1:0] box_w;
	logic [cbg_pkg::COORD_W-1:0] box_h;
	logic [cbg_pkg::SCALE_W-1:0] scale_index;
	logic [cbg_pkg::SHIFT_IDX_W-1:0] xshift_index;
	logic [cbg_pkg::SHIFT_IDX_W-1:0] yshift_index;
	logic last_box;

	modport source (
		output valid, box_x, box_y, box_w, box_h, scale_index, xshift_index,
			yshift_index, last_box,
		input ready
	);
	modport sink (
		input valid, box_x, box_y, box_w, box_h, scale_index, xshift_index,
			yshift_index, last_box,
		output ready
	);
endinterface

`default_nettype wire

/* src/calibration_box_generator.sv */
// Top level of the calibration box generator: divider, scaling pipeline and box sequencer.
`default_nettype none

// Channel   Direction  Handshake      Carries
// req       in         valid/ready    level_width, win_row, win_col of one detection
// box       out        valid/ready    one calibrated box with its pattern indexes
// apb       in         psel/penable   image_width (0x0), image_height (0x4)
//
// A request is taken into a COORD_W stage pipelined divider that forms the ratio of image
// width to level width, one quotient bit per stage, and then into a multiply stage that
// scales the window. The box sequencer then walks all 45 patterns of one request, one
// pattern per cycle while the box channel does not stall; the sequencer is what sets the
// sustained request rate. A box waits in a holding stage until the next surviving pattern
// or the request's final pattern reaches it.
// Reset clears every valid bit and loads the image size registers with 640 by 480.
// Backpressure on the box channel ripples back stage by stage; bubbles are squeezed out
// and no request or surviving box is dropped or repeated.

module calibration_box_generator #(
	parameter int WINDOW_SIZE = cbg_pkg::WINDOW_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [cbg_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cbg_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cbg_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,

	cbg_req_if.sink req,
	cbg_box_if.source box
);

	localparam int W = cbg_pkg::COORD_W;
	localparam int DIV_N = W;
	// Scaled window size; holds WINDOW_SIZE times the largest ratio.
	localparam int SIZE_W = $clog2(WINDOW_SIZE * (2 ** W));
	localparam int PROD_W = 2 * W;
	localparam int T_W = SIZE_W + cbg_pkg::RECIP_W;
	localparam int WH_W = T_W - cbg_pkg::Q_BITS;
	localparam int MT_W = T_W + cbg_pkg::SHIFT_MUL_W;
	localparam int MAG_W = MT_W - 2 * cbg_pkg::Q_BITS;
	localparam int EDGE_W = PROD_W + 2;
	localparam int SW = cbg_pkg::SCALE_W;
	localparam int XW = cbg_pkg::SHIFT_IDX_W;

	// ------------------------------------------------------------------
	// Configuration registers, read directly by the pipeline. Writes must
	// arrive only while no request is in flight; this is not enforced.
	// ------------------------------------------------------------------
	logic [W-1:0] img_w_q;
	logic [W-1:0] img_h_q;
	cbg_pkg::reg_idx_t reg_sel;

	assign reg_sel = cbg_pkg::reg_idx_t'(paddr[cbg_pkg::REG_SEL_BIT]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= cbg_pkg::IMG_W_RESET;
			img_h_q <= cbg_pkg::IMG_H_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				cbg_pkg::REG_IMAGE_WIDTH: img_w_q <= pwdata[W-1:0];
				cbg_pkg::REG_IMAGE_HEIGHT: img_h_q <= pwdata[W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			cbg_pkg::REG_IMAGE_WIDTH:
				prdata = {{(cbg_pkg::APB_DATA_W - W){1'b0}}, img_w_q};
			cbg_pkg::REG_IMAGE_HEIGHT:
				prdata = {{(cbg_pkg::APB_DATA_W - W){1'b0}}, img_h_q};
		endcase
	end

	// ------------------------------------------------------------------
	// Stage 1: restoring divider, one quotient bit per stage, from the
	// most significant bit of the image width down.
	// ------------------------------------------------------------------
	logic         div_v_s1   [DIV_N];
	logic [W-1:0] div_lw_s1  [DIV_N];
	logic [W-1:0] div_rem_s1 [DIV_N];
	logic [W-1:0] div_q_s1   [DIV_N];
	logic [W-1:0] div_row_s1 [DIV_N];
	logic [W-1:0] div_col_s1 [DIV_N];

	logic         div_rdy    [DIV_N];
	logic         dv_in      [DIV_N];
	logic [W-1:0] dlw_in     [DIV_N];
	logic [W-1:0] drem_in    [DIV_N];
	logic [W-1:0] dq_in      [DIV_N];
	logic [W-1:0] drow_in    [DIV_N];
	logic [W-1:0] dcol_in    [DIV_N];
	logic [W:0]   drem_ext   [DIV_N];
	logic [W:0]   drem_sub   [DIV_N];
	logic         dge        [DIV_N];
	logic [W-1:0] drem_nx    [DIV_N];
	logic [W-1:0] dq_nx      [DIV_N];

	logic rdy_s2;

	// Ready travels back from the last divider stage to the request port.
	always_comb begin
		for (int k = DIV_N - 1; k >= 0; k--) begin
			if (k == DIV_N - 1) begin
				div_rdy[k] = !div_v_s1[k] || rdy_s2;
			end else begin
				div_rdy[k] = !div_v_s1[k] || div_rdy[k + 1];
			end
		end
	end

	assign req.ready = div_rdy[0];

	always_comb begin
		for (int k = 0; k < DIV_N; k++) begin
			if (k == 0) begin
				dv_in[k] = req.valid;
				dlw_in[k] = req.level_width;
				drem_in[k] = '0;
				dq_in[k] = '0;
				drow_in[k] = req.win_row;
				dcol_in[k] = req.win_col;
			end else begin
				dv_in[k] = div_v_s1[k - 1];
				dlw_in[k] = div_lw_s1[k - 1];
				drem_in[k] = div_rem_s1[k - 1];
				dq_in[k] = div_q_s1[k - 1];
				drow_in[k] = div_row_s1[k - 1];
				dcol_in[k] = div_col_s1[k - 1];
			end
			drem_ext[k] = {drem_in[k], img_w_q[DIV_N - 1 - k]};
			drem_sub[k] = drem_ext[k] - {1'b0, dlw_in[k]};
			dge[k] = drem_ext[k] >= {1'b0, dlw_in[k]};
			drem_nx[k] = dge[k] ? drem_sub[k][W-1:0] : drem_ext[k][W-1:0];
			dq_nx[k] = {dq_in[k][W-2:0], dge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_N; k++) begin
				div_v_s1[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < DIV_N; k++) begin
				if (div_rdy[k]) begin
					div_v_s1[k] <= dv_in[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_N; k++) begin
			if (div_rdy[k]) begin
				div_lw_s1[k] <= dlw_in[k];
				div_rem_s1[k] <= drem_nx[k];
				div_q_s1[k] <= dq_nx[k];
				div_row_s1[k] <= drow_in[k];
				div_col_s1[k] <= dcol_in[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: scale the window and its corner by the ratio. A zero level
	// width would leave an all-ones quotient, so the ratio is forced to 0.
	// ------------------------------------------------------------------
	logic              mul_v_s2;
	logic [SIZE_W-1:0] size_s2;
	logic [PROD_W-1:0] px_s2;
	logic [PROD_W-1:0] py_s2;
	logic [W-1:0]      mult;
	logic              rdy_s3;

	assign mult = (div_lw_s1[DIV_N - 1] == '0) ? '0 : div_q_s1[DIV_N - 1];
	assign rdy_s2 = !mul_v_s2 || rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			mul_v_s2 <= div_v_s1[DIV_N - 1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			size_s2 <= SIZE_W'(SIZE_W'(mult) * SIZE_W'(WINDOW_SIZE));
			px_s2 <= PROD_W'(div_col_s1[DIV_N - 1]) * PROD_W'(mult);
			py_s2 <= PROD_W'(div_row_s1[DIV_N - 1]) * PROD_W'(mult);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: pattern sequencer. Holds one scaled window and issues its
	// 45 patterns, one per cycle unless stalled from downstream; the next
	// window loads as the last pattern leaves.
	// ------------------------------------------------------------------
	logic              seq_v_s3;
	logic [SIZE_W-1:0] size_s3;
	logic [PROD_W-1:0] px_s3;
	logic [PROD_W-1:0] py_s3;
	logic [SW-1:0]     sn_q;
	logic [XW-1:0]     xn_q;
	logic [XW-1:0]     yn_q;
	logic              rdy_s4;
	logic              issue;
	logic              pat_end;

	assign issue = seq_v_s3 && rdy_s4;
	assign pat_end = (sn_q == SW'(cbg_pkg::NUM_SCALES - 1))
		&& (xn_q == XW'(cbg_pkg::NUM_SHIFTS - 1))
		&& (yn_q == XW'(cbg_pkg::NUM_SHIFTS - 1));
	assign rdy_s3 = !seq_v_s3 || (issue && pat_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_v_s3 <= 1'b0;
			sn_q <= '0;
			xn_q <= '0;
			yn_q <= '0;
		end else begin
			if (rdy_s3) begin
				seq_v_s3 <= mul_v_s2;
			end
			if (issue) begin
				if (pat_end) begin
					sn_q <= '0;
					xn_q <= '0;
					yn_q <= '0;
				end else if (yn_q == XW'(cbg_pkg::NUM_SHIFTS - 1)) begin
					yn_q <= '0;
					if (xn_q == XW'(cbg_pkg::NUM_SHIFTS - 1)) begin
						xn_q <= '0;
						sn_q <= sn_q + SW'(1);
					end else begin
						xn_q <= xn_q + XW'(1);
					end
				end else begin
					yn_q <= yn_q + XW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			size_s3 <= size_s2;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: window size times the scale reciprocal.
	// ------------------------------------------------------------------
	logic              v_s4;
	logic [T_W-1:0]    t_s4;
	logic [PROD_W-1:0] px_s4;
	logic [PROD_W-1:0] py_s4;
	logic [SW-1:0]     sn_s4;
	logic [XW-1:0]     xn_s4;
	logic [XW-1:0]     yn_s4;
	logic              end_s4;
	logic              rdy_s5;

	assign rdy_s4 = !v_s4 || rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			t_s4 <= T_W'(size_s3) * T_W'(cbg_pkg::recip_q14(sn_q));
			px_s4 <= px_s3;
			py_s4 <= py_s3;
			sn_s4 <= sn_q;
			xn_s4 <= xn_q;
			yn_s4 <= yn_q;
			end_s4 <= pat_end;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: box side and shift offset, both truncated.
	// ------------------------------------------------------------------
	logic              v_s5;
	logic [WH_W-1:0]   wh_s5;
	logic [MAG_W-1:0]  mag_s5;
	logic [PROD_W-1:0] px_s5;
	logic [PROD_W-1:0] py_s5;
	logic [SW-1:0]     sn_s5;
	logic [XW-1:0]     xn_s5;
	logic [XW-1:0]     yn_s5;
	logic              end_s5;
	logic [MT_W-1:0]   mt;
	logic              rdy_s6;

	assign mt = MT_W'(t_s4) * MT_W'(cbg_pkg::SHIFT_Q14);
	assign rdy_s5 = !v_s5 || rdy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			wh_s5 <= WH_W'(t_s4 >> cbg_pkg::Q_BITS);
			mag_s5 <= MAG_W'(mt >> (2 * cbg_pkg::Q_BITS));
			px_s5 <= px_s4;
			py_s5 <= py_s4;
			sn_s5 <= sn_s4;
			xn_s5 <= xn_s4;
			yn_s5 <= yn_s4;
			end_s5 <= end_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: shifted edges, the outside test and clamping at zero.
	// ------------------------------------------------------------------
	logic                     v_s6;
	logic                     keep_s6;
	logic [W-1:0]             bx_s6;
	logic [W-1:0]             by_s6;
	logic [WH_W-1:0]          wh_s6;
	logic [SW-1:0]            sn_s6;
	logic [XW-1:0]            xn_s6;
	logic [XW-1:0]            yn_s6;
	logic                     end_s6;
	logic signed [EDGE_W-1:0] px_e;
	logic signed [EDGE_W-1:0] py_e;
	logic signed [EDGE_W-1:0] mag_e;
	logic signed [EDGE_W-1:0] iw_e;
	logic signed [EDGE_W-1:0] ih_e;
	logic signed [EDGE_W-1:0] bx;
	logic signed [EDGE_W-1:0] by;
	logic                     keep;
	logic                     rdy_s7;

	assign px_e = $signed({2'b00, px_s5});
	assign py_e = $signed({2'b00, py_s5});
	assign mag_e = $signed(EDGE_W'(mag_s5));
	assign iw_e = $signed(EDGE_W'(img_w_q));
	assign ih_e = $signed(EDGE_W'(img_h_q));

	always_comb begin
		case (xn_s5)
			cbg_pkg::SHIFT_NEG: bx = px_e + mag_e;
			cbg_pkg::SHIFT_POS: bx = px_e - mag_e;
			cbg_pkg::SHIFT_ZERO: bx = px_e;
			default: bx = px_e;
		endcase
		case (yn_s5)
			cbg_pkg::SHIFT_NEG: by = py_e + mag_e;
			cbg_pkg::SHIFT_POS: by = py_e - mag_e;
			cbg_pkg::SHIFT_ZERO: by = py_e;
			default: by = py_e;
		endcase
	end

	// A box whose corner lies at or past the image edge is dropped.
	assign keep = !((bx >= iw_e) || (by >= ih_e));
	assign rdy_s6 = !v_s6 || rdy_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (rdy_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			keep_s6 <= keep;
			bx_s6 <= bx[EDGE_W-1] ? '0 : bx[W-1:0];
			by_s6 <= by[EDGE_W-1] ? '0 : by[W-1:0];
			wh_s6 <= wh_s5;
			sn_s6 <= sn_s5;
			xn_s6 <= xn_s5;
			yn_s6 <= yn_s5;
			end_s6 <= end_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: clamp the box size to the image's right and bottom edges.
	// ------------------------------------------------------------------
	logic         v_s7;
	logic         keep_s7;
	logic         end_s7;
	logic [W-1:0] bx_s7;
	logic [W-1:0] by_s7;
	logic [W-1:0] bw_s7;
	logic [W-1:0] bh_s7;
	logic [SW-1:0] sn_s7;
	logic [XW-1:0] xn_s7;
	logic [XW-1:0] yn_s7;
	logic [W-1:0] lim_w;
	logic [W-1:0] lim_h;
	logic         c_take;

	assign lim_w = img_w_q - bx_s6;
	assign lim_h = img_h_q - by_s6;
	assign rdy_s7 = !v_s7 || c_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (rdy_s7) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			keep_s7 <= keep_s6;
			end_s7 <= end_s6;
			bx_s7 <= bx_s6;
			by_s7 <= by_s6;
			bw_s7 <= (wh_s6 > WH_W'(lim_w)) ? lim_w : wh_s6[W-1:0];
			bh_s7 <= (wh_s6 > WH_W'(lim_h)) ? lim_h : wh_s6[W-1:0];
			sn_s7 <= sn_s6;
			xn_s7 <= xn_s6;
			yn_s7 <= yn_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: one surviving box is held back until it is known whether
	// another survivor of the same request follows, which settles its
	// last flag. It leaves when the next survivor arrives or when the
	// request's final pattern has gone by.
	// ------------------------------------------------------------------
	logic          pv_s8;
	logic          pfin_s8;
	logic [W-1:0]  px_box_s8;
	logic [W-1:0]  py_box_s8;
	logic [W-1:0]  pw_s8;
	logic [W-1:0]  ph_s8;
	logic [SW-1:0] psn_s8;
	logic [XW-1:0] pxn_s8;
	logic [XW-1:0] pyn_s8;
	logic          o_free;
	logic          pend_move;

	logic          ov_s9;
	logic [W-1:0]  ox_s9;
	logic [W-1:0]  oy_s9;
	logic [W-1:0]  ow_s9;
	logic [W-1:0]  oh_s9;
	logic [SW-1:0] osn_s9;
	logic [XW-1:0] oxn_s9;
	logic [XW-1:0] oyn_s9;
	logic          olast_s9;

	assign o_free = !ov_s9 || box.ready;
	// A dropped pattern needs no slot; a survivor needs the held slot to be free or leaving.
	assign c_take = v_s7 && (!keep_s7 || !pv_s8 || o_free);
	assign pend_move = pv_s8 && o_free && (pfin_s8 || (v_s7 && keep_s7));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s8 <= 1'b0;
			pfin_s8 <= 1'b0;
		end else if (c_take && keep_s7) begin
			pv_s8 <= 1'b1;
			pfin_s8 <= end_s7;
		end else if (pend_move) begin
			pv_s8 <= 1'b0;
		end else if (c_take && end_s7 && pv_s8) begin
			pfin_s8 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (c_take && keep_s7) begin
			px_box_s8 <= bx_s7;
			py_box_s8 <= by_s7;
			pw_s8 <= bw_s7;
			ph_s8 <= bh_s7;
			psn_s8 <= sn_s7;
			pxn_s8 <= xn_s7;
			pyn_s8 <= yn_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: output register facing the box channel.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_s9 <= 1'b0;
		end else if (pend_move) begin
			ov_s9 <= 1'b1;
		end else if (box.ready) begin
			ov_s9 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_move) begin
			ox_s9 <= px_box_s8;
			oy_s9 <= py_box_s8;
			ow_s9 <= pw_s8;
			oh_s9 <= ph_s8;
			osn_s9 <= psn_s8;
			oxn_s9 <= pxn_s8;
			oyn_s9 <= pyn_s8;
			olast_s9 <= pfin_s8;
		end
	end

	assign box.valid = ov_s9;
	assign box.box_x = ox_s9;
	assign box.box_y = oy_s9;
	assign box.box_w = ow_s9;
	assign box.box_h = oh_s9;
	assign box.scale_index = osn_s9;
	assign box.xshift_index = oxn_s9;
	assign box.yshift_index = oyn_s9;
	assign box.last_box = olast_s9;

endmodule

`default_nettype wire

/* src/cbg_checker.sv */
// Port level checks of the calibration box generator and their binding to the top level.
`default_nettype none

module cbg_checker (
	input logic clk,
	input logic arst_n,
	input logic box_valid,
	input logic box_ready,
	input logic [cbg_pkg::COORD_W-1:0] box_x,
	input logic [cbg_pkg::COORD_W-1:0] box_y,
	input logic [cbg_pkg::COORD_W-1:0] box_w,
	input logic [cbg_pkg::COORD_W-1:0] box_h,
	input logic [cbg_pkg::SCALE_W-1:0] scale_index,
	input logic [cbg_pkg::SHIFT_IDX_W-1:0] xshift_index,
	input logic [cbg_pkg::SHIFT_IDX_W-1:0] yshift_index,
	input logic last_box
);

	localparam int PW = cbg_pkg::PATTERN_W;
	localparam int SW = cbg_pkg::SCALE_W;
	localparam int XW = cbg_pkg::SHIFT_IDX_W;

	logic [PW-1:0] code;
	logic [PW-1:0] code_q;
	logic          open_q;

	// Position of a pattern in emission order.
	assign code = PW'(scale_index) * PW'(cbg_pkg::NUM_SHIFTS * cbg_pkg::NUM_SHIFTS)
		+ PW'(xshift_index) * PW'(cbg_pkg::NUM_SHIFTS) + PW'(yshift_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			code_q <= '0;
		end else if (box_valid && box_ready) begin
			open_q <= !last_box;
			code_q <= code;
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && !box_ready |=> box_valid)
		else $error("box valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && !box_ready |=> $stable({box_x, box_y, box_w, box_h, scale_index,
			xshift_index, yshift_index, last_box}))
		else $error("box payload changed while stalled");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> (scale_index <= SW'(cbg_pkg::NUM_SCALES - 1))
			&& (xshift_index <= XW'(cbg_pkg::NUM_SHIFTS - 1))
			&& (yshift_index <= XW'(cbg_pkg::NUM_SHIFTS - 1)))
		else $error("box pattern index out of range");

	// Within one request, boxes leave in strictly rising pattern order.
	a_pattern_order: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && box_ready && open_q |-> code > code_q)
		else $error("box pattern order broken within a request");

endmodule

bind calibration_box_generator cbg_checker u_cbg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.box_valid(box.valid),
	.box_ready(box.ready),
	.box_x(box.box_x),
	.box_y(box.box_y),
	.box_w(box.box_w),
	.box_h(box.box_h),
	.scale_index(box.scale_index),
	.xshift_index(box.xshift_index),
	.yshift_index(box.yshift_index),
	.last_box(box.last_box)
);

`default_nettype wire
